/* hw/rtl/shg_pkg.sv */
`default_nettype none

package shg_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int NOW_W          = 32;
  localparam int PER_W          = 20;
  localparam int STEPS_W        = 16;
  localparam int REG_IDX_W      = 3;

  localparam logic [PER_W-1:0]   PERIOD_US_RST    = 20'd3822;
  localparam logic [STEPS_W-1:0] RETURN_STEPS_RST = 16'd200;
  localparam logic [PER_W-1:0]   CHECK_PERIOD_RST = 20'd1000;
  localparam logic [PER_W-1:0]   CHECK_HALF_RST   = 20'd500;
  localparam logic               START_DIR_RST    = 1'b0;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PERIOD_US    = 3'd0,
    REG_RETURN_STEPS = 3'd1,
    REG_CHECK_PERIOD = 3'd2,
    REG_CHECK_HALF   = 3'd3,
    REG_START_DIR    = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_START = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [NOW_W-1:0] now_us;
    logic             limit_hit;
  } in_t;

  typedef struct packed {
    logic step_out;
    logic dir_out;
    logic enable_out;
  } out_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] index;
    logic [PER_W-1:0]     wdata;
  } cfg_t;

  // control of the shared remainder unit
  typedef struct packed {
    logic clear;
    logic shift;
    logic bit_in;
  } rem_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/shg_if.sv */
`default_nettype none

interface shg_in_if import shg_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface shg_out_if import shg_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface shg_cfg_if import shg_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/stepper_homing_run_generator.sv */
// Stepper homing run generator.
// in_item carries a start command or a time sample (kind, now_us, limit_hit);
// every accepted item yields exactly one result on out_item with the step,
// direction and enable levels. cfg takes register writes at any time it is
// valid (ready is always high); write it only while the block is idle.
// A start command, or a sample while no run is active, goes from S_IDLE
// straight to S_DONE, which loads the output register once it is free. A
// sample during a run passes S_STEP_DIV, S_STEP_UPD, S_CHK_DIV, S_CHK_UPD and
// S_DONE: one bit-serial remainder unit works out now mod period_us, one time
// bit per cycle, the step update is applied, then the unit works out now mod
// check_period and the limit-check update is applied.
// in_item is ready only while no item is in work, so one item at a time.
// A finished result sits in the output register; the next item is taken
// while it waits, and that item's result is held back until out_item takes
// the earlier one. Reset (rst, synchronous) stops any run, clears all
// levels and the pending result, and restores the register defaults.
`default_nettype none

module stepper_homing_run_generator import shg_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  shg_in_if.sink       in_item,
  shg_out_if.source    out_item,
  shg_cfg_if.sink      cfg
);

  localparam int SER_W = (TIME_WIDTH < NOW_W) ? TIME_WIDTH : NOW_W;
  localparam int CNT_W = $clog2(SER_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SER_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP_DIV,
    S_STEP_UPD,
    S_CHK_DIV,
    S_CHK_UPD,
    S_DONE
  } state_t;

  state_t state;

  logic [PER_W-1:0]   period_us;
  logic [STEPS_W-1:0] return_steps;
  logic [PER_W-1:0]   check_period;
  logic [PER_W-1:0]   check_half;
  logic               start_dir;

  logic               running;
  logic               step_level;
  logic               direction;
  logic               check_phase;
  logic [STEPS_W-1:0] steps_left;

  logic [SER_W-1:0]   t_shift;
  logic               limit_q;
  logic [CNT_W-1:0]   cnt;
  logic               out_valid;
  out_t               out_data;

  rem_ctl_t           rem_ctl;
  logic [PER_W-1:0]   divisor;
  logic [PER_W-1:0]   rem;
  logic [PER_W-1:0]   step_div;
  logic [PER_W-1:0]   chk_div;
  logic               want;
  logic               cwant;
  logic [STEPS_W-1:0] steps_dec;
  logic               in_xfer;

  assign in_xfer        = in_item.valid && in_item.ready;
  assign in_item.ready  = (state == S_IDLE);
  assign cfg.ready      = 1'b1;
  assign out_item.valid = out_valid;
  assign out_item.data  = out_data;

  // a zero period behaves as a period of one
  assign step_div = (period_us == '0) ? PER_W'(1) : period_us;
  assign chk_div  = (check_period == '0) ? PER_W'(1) : check_period;
  assign divisor  = (state == S_CHK_DIV) ? chk_div : step_div;

  assign rem_ctl.clear  = in_xfer || (state == S_STEP_UPD);
  assign rem_ctl.shift  = (state == S_STEP_DIV) || (state == S_CHK_DIV);
  assign rem_ctl.bit_in = t_shift[SER_W-1];

  assign want      = (rem <= (period_us >> 1));
  assign cwant     = (rem <= check_half);
  assign steps_dec = steps_left - STEPS_W'(1);

  shg_rem_unit u_rem (
    .clk     (clk),
    .ctl     (rem_ctl),
    .divisor (divisor),
    .rem     (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      period_us    <= PERIOD_US_RST;
      return_steps <= RETURN_STEPS_RST;
      check_period <= CHECK_PERIOD_RST;
      check_half   <= CHECK_HALF_RST;
      start_dir    <= START_DIR_RST;
      running      <= 1'b0;
      step_level   <= 1'b0;
      direction    <= 1'b0;
      check_phase  <= 1'b0;
      steps_left   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.data.index)
          REG_PERIOD_US:    period_us    <= cfg.data.wdata;
          REG_RETURN_STEPS: return_steps <= cfg.data.wdata[STEPS_W-1:0];
          REG_CHECK_PERIOD: check_period <= cfg.data.wdata;
          REG_CHECK_HALF:   check_half   <= cfg.data.wdata;
          REG_START_DIR:    start_dir    <= cfg.data.wdata[0];
          default: ;
        endcase
      end

      if (out_valid && out_item.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_item.valid) begin
            t_shift <= in_item.data.now_us[SER_W-1:0];
            limit_q <= in_item.data.limit_hit;
            cnt     <= CNT_LAST;
            if (in_item.data.kind == KIND_START) begin
              running     <= 1'b1;
              step_level  <= 1'b0;
              check_phase <= 1'b0;
              direction   <= start_dir;
              steps_left  <= return_steps;
              state       <= S_DONE;
            end else if (running) begin
              state <= S_STEP_DIV;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_STEP_DIV: begin
          // rotate so the time word is back in place after a full pass
          t_shift <= {t_shift[SER_W-2:0], t_shift[SER_W-1]};
          cnt     <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= S_STEP_UPD;
          end
        end
        S_STEP_UPD: begin
          cnt <= CNT_LAST;
          if (want != step_level) begin
            if (direction != start_dir) begin
              steps_left <= steps_dec;
              if (steps_dec == '0) begin
                running     <= 1'b0;
                step_level  <= 1'b0;
                check_phase <= 1'b0;
              end else begin
                step_level <= want;
              end
            end else begin
              step_level <= want;
            end
          end
          state <= S_CHK_DIV;
        end
        S_CHK_DIV: begin
          t_shift <= {t_shift[SER_W-2:0], t_shift[SER_W-1]};
          cnt     <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= S_CHK_UPD;
          end
        end
        S_CHK_UPD: begin
          if (cwant != check_phase) begin
            check_phase <= cwant;
            // reversal on a rising check edge while the limit is hit, once per run
            if (cwant && (direction == start_dir) && limit_q) begin
              direction <= ~start_dir;
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_item.ready) begin
            out_valid           <= 1'b1;
            out_data.step_out   <= step_level;
            out_data.dir_out    <= direction;
            out_data.enable_out <= running;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (in_item.data.kind == KIND_START)) |=>
      (running && (steps_left == $past(return_steps)) && (direction == $past(start_dir))))
    else $error("start did not load the run state");

  a_step_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP_UPD) |-> (rem < step_div))
    else $error("step remainder not below period");

  a_chk_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK_UPD) |-> (rem < chk_div))
    else $error("check remainder not below check period");

  a_stop_reversed: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(running)) |-> (direction != start_dir))
    else $error("run stopped without a reversal");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state != S_IDLE))
    else $error("item taken but block still idle");

endmodule

`default_nettype wire

/* hw/rtl/shg_rem_unit.sv */
`default_nettype none

// restoring remainder, one dividend bit per cycle while shift is set, msb first
module shg_rem_unit import shg_pkg::*; (
  input  logic             clk,
  input  rem_ctl_t         ctl,
  input  logic [PER_W-1:0] divisor,
  output logic [PER_W-1:0] rem
);

  logic [PER_W:0]   trial;
  logic [PER_W:0]   diff;
  logic [PER_W-1:0] rem_next;

  always_comb begin
    trial = {rem, ctl.bit_in};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      rem_next = diff[PER_W-1:0];
    end else begin
      rem_next = trial[PER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      rem <= '0;
    end else if (ctl.shift) begin
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire
